@@ hdl/http_request_byte_parser_macros.svh @@
// Assertion helpers shared by the parser's assertion section.
// Both sample on the rising edge of clk and are disabled while rst is high.
`ifndef HTTP_REQUEST_BYTE_PARSER_MACROS_SVH
`define HTTP_REQUEST_BYTE_PARSER_MACROS_SVH

// Same-cycle implication.
`define HRBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HRBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/hrbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hrbp_pkg;

  // Byte classes.
  localparam logic [2:0] CLS_METHOD  = 3'd0;
  localparam logic [2:0] CLS_TARGET  = 3'd1;
  localparam logic [2:0] CLS_VERSION = 3'd2;
  localparam logic [2:0] CLS_SPACE   = 3'd3;
  localparam logic [2:0] CLS_HEADER  = 3'd4;
  localparam logic [2:0] CLS_CRLF    = 3'd5;
  localparam logic [2:0] CLS_BODY    = 3'd6;
  localparam logic [2:0] CLS_AFTER   = 3'd7;

  // Parse phases.
  localparam logic [1:0] PH_REQ  = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Content-Length number conversion stages.
  localparam logic [1:0] NUM_SKIP   = 2'd0;
  localparam logic [1:0] NUM_SIGN   = 2'd1;
  localparam logic [1:0] NUM_DIGITS = 2'd2;
  localparam logic [1:0] NUM_END    = 2'd3;

  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_K     = 8'h6B;

  localparam logic [4:0] LEN_PREFIX_SIZE  = 5'd15;
  localparam logic [4:0] CONN_PREFIX_SIZE = 5'd11;
  localparam logic [3:0] KW_SIZE          = 4'd10;
  localparam logic [4:0] LINE_POS_MAX     = 5'd16;
  localparam logic [1:0] TOKEN_MAX        = 2'd3;
  localparam logic [30:0] LEN_MAX         = 31'h7FFF_FFFF;

  localparam logic [7:0] LEN_PREFIX [15] = '{
    "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h", ":"
  };
  localparam logic [7:0] CONN_PREFIX [11] = '{
    "c", "o", "n", "n", "e", "c", "t", "i", "o", "n", ":"
  };
  localparam logic [7:0] KEYWORD [10] = '{
    "k", "e", "e", "p", "-", "a", "l", "i", "v", "e"
  };

  // Character as the line logic sees it.
  typedef struct packed {
    logic [7:0] lower;
    logic       space;
    logic       digit;
  } chr_t;

  // One classified input byte as carried through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       start_new;
    logic       is_cr;
    logic       is_lf;
    chr_t       info;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic        cr_pending;
    logic [4:0]  line_pos;
    logic        len_match;
    logic        conn_match;
    logic [1:0]  num_stage;
    logic        num_neg;
    logic [30:0] length_value;
    logic [3:0]  kw_pos;
    logic        keepalive;
    logic [1:0]  token_index;
    logic        inside_token;
    logic [30:0] body_count;
  } parse_st_t;

  typedef struct packed {
    parse_st_t  st;
    logic [2:0] cls;
  } line_res_t;

  localparam parse_st_t ST_RESET = '{
    phase:        PH_REQ,
    cr_pending:   1'b0,
    line_pos:     5'd0,
    len_match:    1'b1,
    conn_match:   1'b1,
    num_stage:    NUM_SKIP,
    num_neg:      1'b0,
    length_value: 31'd0,
    kw_pos:       4'd0,
    keepalive:    1'b0,
    token_index:  2'd0,
    inside_token: 1'b0,
    body_count:   31'd0
  };

  localparam chr_t CR_INFO = '{lower: CHR_CR, space: 1'b1, digit: 1'b0};

  function automatic chr_t classify(logic [7:0] c);
    chr_t r;
    r.lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    r.space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    r.digit = (c >= "0" && c <= "9");
    return r;
  endfunction

  function automatic parse_st_t feed_number(parse_st_t s_in, chr_t c);
    parse_st_t  s;
    logic [34:0] v;
    s = s_in;
    v = '0;
    if (s.num_stage == NUM_SKIP && c.space) begin
      s.num_stage = NUM_SKIP;
    end else if (s.num_stage == NUM_SKIP && (c.lower == CHR_PLUS || c.lower == CHR_MINUS)) begin
      s.num_neg   = (c.lower == CHR_MINUS);
      s.num_stage = NUM_SIGN;
    end else if (s.num_stage == NUM_END) begin
      s.num_stage = NUM_END;
    end else if (!c.digit) begin
      s.num_stage = NUM_END;
    end else begin
      s.num_stage = NUM_DIGITS;
      if (!s.num_neg) begin
        // Times ten as two shifts and an add, then saturate.
        v = ({4'd0, s.length_value} << 3) + ({4'd0, s.length_value} << 1)
            + {31'd0, c.lower[3:0]};
        s.length_value = (v > {4'd0, LEN_MAX}) ? LEN_MAX : v[30:0];
      end
    end
    return s;
  endfunction

  function automatic parse_st_t feed_keyword(parse_st_t s_in, chr_t c);
    parse_st_t s;
    s = s_in;
    if (s.kw_pos < KW_SIZE) begin
      if (c.lower == KEYWORD[s.kw_pos]) begin
        s.kw_pos = s.kw_pos + 4'd1;
      end else begin
        s.kw_pos = (c.lower == CHR_K) ? 4'd1 : 4'd0;
      end
      if (s.kw_pos == KW_SIZE) begin
        s.keepalive = 1'b1;
      end
    end
    return s;
  endfunction

  // One ordinary character of the request line or a header line.
  function automatic line_res_t line_char(parse_st_t s_in, chr_t c);
    parse_st_t  s;
    logic [4:0] p;
    line_res_t  r;
    s = s_in;
    r.cls = CLS_HEADER;
    if (s.phase == PH_REQ) begin
      if (c.space) begin
        if (s.inside_token) begin
          s.inside_token = 1'b0;
          if (s.token_index < TOKEN_MAX) begin
            s.token_index = s.token_index + 2'd1;
          end
        end
        r.cls = CLS_SPACE;
      end else begin
        s.inside_token = 1'b1;
        r.cls = {1'b0, s.token_index};
      end
    end else begin
      p = s.line_pos;
      if (p < LINE_POS_MAX) begin
        s.line_pos = p + 5'd1;
      end
      if (s.len_match) begin
        if (p < LEN_PREFIX_SIZE) begin
          if (c.lower != LEN_PREFIX[p[3:0]]) begin
            s.len_match = 1'b0;
          end else if (p == LEN_PREFIX_SIZE - 5'd1) begin
            s.length_value = '0;
            s.num_stage    = NUM_SKIP;
            s.num_neg      = 1'b0;
          end
        end else begin
          s = feed_number(s, c);
        end
      end
      if (s.conn_match) begin
        if (p < CONN_PREFIX_SIZE) begin
          if (c.lower != CONN_PREFIX[p[3:0]]) begin
            s.conn_match = 1'b0;
          end else if (p == CONN_PREFIX_SIZE - 5'd1) begin
            s.keepalive = 1'b0;
            s.kw_pos    = '0;
          end
        end else begin
          s = feed_keyword(s, c);
        end
      end
    end
    r.st = s;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/hrbp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hrbp_front (
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [7:0]     data_byte,
  input  wire logic           start_new,
  input  wire hrbp_pkg::q_stat_t q_stat,
  output logic                push,
  output hrbp_pkg::item_t     item
);
  import hrbp_pkg::*;

  // The front only refuses a byte when the queue has no free entry.
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    item.data      = data_byte;
    item.start_new = start_new;
    item.is_cr     = (data_byte == CHR_CR);
    item.is_lf     = (data_byte == CHR_LF);
    item.info      = classify(data_byte);
  end

endmodule

`default_nettype wire

@@ hdl/hrbp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hrbp_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire hrbp_pkg::item_t push_item,
  input  wire logic            pop,
  output hrbp_pkg::item_t      head,
  output hrbp_pkg::q_stat_t    q_stat
);
  import hrbp_pkg::*;

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head         = entries[rd_ptr];
  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

@@ hdl/hrbp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hrbp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hrbp_pkg::item_t   head,
  input  wire hrbp_pkg::q_stat_t q_stat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             byte_out,
  output logic [2:0]             byte_class,
  output logic                   request_done,
  output logic [1:0]             parse_phase,
  output logic [30:0]            body_length,
  output logic                   conn_persist
);
  import hrbp_pkg::*;

  parse_st_t st;
  parse_st_t st_next;
  logic [2:0] cls_next;
  logic       done_next;

  // A byte leaves the queue whenever the output register is free or is being drained.
  assign pop = !q_stat.empty && (!out_valid || !out_stall);

  always_comb begin
    parse_st_t s;
    line_res_t r_cr;
    line_res_t r_ch;
    s         = head.start_new ? ST_RESET : st;
    cls_next  = CLS_HEADER;
    done_next = 1'b0;
    // A held CR that turns out not to start a line break counts as white space.
    r_cr = line_char(s, CR_INFO);
    r_ch = r_cr;
    if (s.phase == PH_DONE) begin
      cls_next = CLS_AFTER;
    end else if (s.phase == PH_BODY) begin
      cls_next     = CLS_BODY;
      s.body_count = s.body_count + 31'd1;
      if (s.body_count >= s.length_value) begin
        s.phase   = PH_DONE;
        done_next = 1'b1;
      end
    end else if (head.is_cr) begin
      if (s.cr_pending) begin
        s = r_cr.st;
      end
      s.cr_pending = 1'b1;
      cls_next     = CLS_CRLF;
    end else if (head.is_lf && s.cr_pending) begin
      s.cr_pending = 1'b0;
      cls_next     = CLS_CRLF;
      if (s.phase == PH_REQ) begin
        s.phase = PH_HDR;
      end else if (s.line_pos == 5'd0) begin
        if (s.length_value != 31'd0) begin
          s.phase      = PH_BODY;
          s.body_count = '0;
        end else begin
          s.phase   = PH_DONE;
          done_next = 1'b1;
        end
      end
      s.line_pos   = '0;
      s.len_match  = 1'b1;
      s.conn_match = 1'b1;
      s.num_stage  = NUM_SKIP;
      s.num_neg    = 1'b0;
      s.kw_pos     = '0;
    end else begin
      if (s.cr_pending) begin
        s            = r_cr.st;
        s.cr_pending = 1'b0;
      end
      r_ch     = line_char(s, head.info);
      s        = r_ch.st;
      cls_next = r_ch.cls;
    end
    st_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_RESET;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_out     <= head.data;
      byte_class   <= cls_next;
      request_done <= done_next;
      parse_phase  <= st_next.phase;
      body_length  <= st_next.length_value;
      conn_persist <= st_next.keepalive;
    end
  end

endmodule

`default_nettype wire

@@ hdl/http_request_byte_parser.sv @@
// HTTP/1.1 request byte tagger.
// Input channel: in_valid / in_stall with data_byte and start_new. A transfer
// happens on a rising edge with in_valid high and in_stall low. Setting
// start_new clears all parse state before that byte is handled.
// Output channel: out_valid / out_stall with one result per input byte:
// byte_out, byte_class, request_done, parse_phase, body_length, conn_persist.
// Structure: the front classifies each byte (case folding, white space and
// digit tests) into a two-entry queue; the back runs the parse state update
// and loads the output register.
// A byte transferred at the input is written into the queue, then goes
// through the back's state update into the output register. Throughput: one
// byte per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its result and the
// queue absorbs up to two more bytes before in_stall rises.
// Reset (rst, synchronous) empties the queue and output register and puts
// the parser at the start of a request line with no length and no keep-alive.
`timescale 1ns / 1ps
`default_nettype none
`include "http_request_byte_parser_macros.svh"

module http_request_byte_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_new,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       byte_out,
  output logic [2:0]       byte_class,
  output logic             request_done,
  output logic [1:0]       parse_phase,
  output logic [30:0]      body_length,
  output logic             conn_persist
);
  import hrbp_pkg::*;

  q_stat_t q_stat;
  item_t   push_item;
  item_t   head;
  logic    push;
  logic    pop;

  hrbp_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .start_new (start_new),
    .q_stat    (q_stat),
    .push      (push),
    .item      (push_item)
  );

  hrbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  hrbp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_out     (byte_out),
    .byte_class   (byte_class),
    .request_done (request_done),
    .parse_phase  (parse_phase),
    .body_length  (body_length),
    .conn_persist (conn_persist)
  );

  `HRBP_ASSERT_NOW(a_done_phase, out_valid && request_done, parse_phase == PH_DONE, "request_done without done phase")
  `HRBP_ASSERT_NOW(a_after_done, out_valid && byte_class == CLS_AFTER, !request_done && parse_phase == PH_DONE, "bad byte after done")
  `HRBP_ASSERT_NOW(a_body_len, out_valid && parse_phase == PH_BODY, body_length != 31'd0, "body phase with zero length")
  `HRBP_ASSERT_NEXT(a_queue_fill, in_valid && !in_stall, !q_stat.empty, "accepted byte missing from queue")

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import hrbp_pkg::*;

  typedef struct packed {
    logic [7:0]  data;
    logic [2:0]  cls;
    logic        done;
    logic [1:0]  phase;
    logic [30:0] clen;
    logic        keep;
  } byte_tag_t;

  typedef struct packed {
    logic [7:0] b;
    logic       sn;
    logic       typed;
    byte_tag_t  want;
  } in_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       sn;
    logic       typed;
    logic [2:0] cls;
    logic       done;
    logic [1:0] ph;
  } script_row_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        start_new = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  byte_out;
  logic [2:0]  byte_class;
  logic        request_done;
  logic [1:0]  parse_phase;
  logic [30:0] body_length;
  logic        conn_persist;

  // Tracked parse state, updated once per accepted byte.
  logic [1:0]  st_phase;
  logic        st_cr_held;
  logic [4:0]  st_line_len;
  logic        st_len_hdr;
  logic        st_conn_hdr;
  logic [1:0]  st_num_stage;
  logic        st_num_neg;
  logic [30:0] st_clen;
  logic [3:0]  st_kw_pos;
  logic        st_keepalive;
  logic [1:0]  st_token;
  logic        st_in_token;
  logic [30:0] st_body_seen;

  byte_tag_t tags_due[$];
  in_item_t  tx_bytes[$];
  int errors = 0;
  int sent = 0;
  int burst_left = 0;
  int stall_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  string verbs[5] = '{"GET", "POST", "PUT", "DELETE", "HEAD"};
  string conn_opts[6] = '{" keep-alive", "close", " Keep-Alive, Upgrade", "kkeep-alive",
                          " keep-aliv", "upgrade,keep-alive"};
  string near_miss[4] = '{"Content-Lengt: 7", "Content-Length 7", "Connection keep-alive",
                          "Connectio: keep-alive"};

  script_row_t opening [25] = '{
    '{"G",    1'b1, 1'b1, CLS_METHOD,  1'b0, PH_REQ},
    '{8'hFF,  1'b0, 1'b1, CLS_METHOD,  1'b0, PH_REQ},
    '{" ",    1'b0, 1'b1, CLS_SPACE,   1'b0, PH_REQ},
    '{"/",    1'b0, 1'b1, CLS_TARGET,  1'b0, PH_REQ},
    '{8'h09,  1'b0, 1'b1, CLS_SPACE,   1'b0, PH_REQ},
    '{"H",    1'b0, 1'b1, CLS_VERSION, 1'b0, PH_REQ},
    '{" ",    1'b0, 1'b1, CLS_SPACE,   1'b0, PH_REQ},
    '{"x",    1'b0, 1'b1, CLS_SPACE,   1'b0, PH_REQ},
    '{CHR_LF, 1'b0, 1'b1, CLS_SPACE,   1'b0, PH_REQ},
    '{CHR_CR, 1'b0, 1'b1, CLS_CRLF,    1'b0, PH_REQ},
    '{CHR_CR, 1'b0, 1'b1, CLS_CRLF,    1'b0, PH_REQ},
    '{CHR_LF, 1'b0, 1'b1, CLS_CRLF,    1'b0, PH_HDR},
    '{8'h00,  1'b0, 1'b0, CLS_HEADER,  1'b0, PH_HDR},
    '{CHR_LF, 1'b0, 1'b0, CLS_HEADER,  1'b0, PH_HDR},
    '{CHR_CR, 1'b0, 1'b1, CLS_CRLF,    1'b0, PH_HDR},
    '{CHR_LF, 1'b0, 1'b0, CLS_CRLF,    1'b0, PH_HDR},
    '{CHR_CR, 1'b0, 1'b1, CLS_CRLF,    1'b0, PH_HDR},
    '{CHR_LF, 1'b0, 1'b1, CLS_CRLF,    1'b1, PH_DONE},
    '{"Z",    1'b0, 1'b1, CLS_AFTER,   1'b0, PH_DONE},
    '{CHR_CR, 1'b0, 1'b1, CLS_AFTER,   1'b0, PH_DONE},
    '{CHR_CR, 1'b1, 1'b1, CLS_CRLF,    1'b0, PH_REQ},
    '{CHR_LF, 1'b0, 1'b1, CLS_CRLF,    1'b0, PH_HDR},
    '{CHR_CR, 1'b0, 1'b1, CLS_CRLF,    1'b0, PH_HDR},
    '{CHR_LF, 1'b0, 1'b1, CLS_CRLF,    1'b1, PH_DONE},
    '{"A",    1'b1, 1'b1, CLS_METHOD,  1'b0, PH_REQ}
  };

  http_request_byte_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .start_new(start_new),
    .out_valid(out_valid), .out_stall(out_stall), .byte_out(byte_out),
    .byte_class(byte_class), .request_done(request_done), .parse_phase(parse_phase),
    .body_length(body_length), .conn_persist(conn_persist)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] lower_case(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void restart_line();
    st_line_len  = 5'd0;
    st_len_hdr   = 1'b1;
    st_conn_hdr  = 1'b1;
    st_num_stage = NUM_SKIP;
    st_num_neg   = 1'b0;
    st_kw_pos    = 4'd0;
  endfunction

  function automatic void clear_parser();
    restart_line();
    st_phase     = PH_REQ;
    st_cr_held   = 1'b0;
    st_clen      = 31'd0;
    st_keepalive = 1'b0;
    st_token     = 2'd0;
    st_in_token  = 1'b0;
    st_body_seen = 31'd0;
  endfunction

  // atoi-style conversion of the Content-Length value, one character at a time.
  function automatic void take_length_char(logic [7:0] c);
    logic [34:0] acc;
    if (st_num_stage == NUM_SKIP && is_blank(c)) return;
    if (st_num_stage == NUM_SKIP && (c == CHR_PLUS || c == CHR_MINUS)) begin
      st_num_neg   = (c == CHR_MINUS);
      st_num_stage = NUM_SIGN;
    end else if (st_num_stage == NUM_END || !(c >= "0" && c <= "9")) begin
      st_num_stage = NUM_END;
    end else begin
      st_num_stage = NUM_DIGITS;
      if (!st_num_neg) begin
        acc = {4'd0, st_clen} * 35'd10 + {31'd0, c[3:0]};
        st_clen = (acc > {4'd0, LEN_MAX}) ? LEN_MAX : acc[30:0];
      end
    end
  endfunction

  function automatic void take_keyword_char(logic [7:0] c);
    logic [7:0] lc;
    lc = lower_case(c);
    if (st_kw_pos >= KW_SIZE) return;
    if (lc == KEYWORD[st_kw_pos]) st_kw_pos = st_kw_pos + 4'd1;
    else st_kw_pos = (lc == CHR_K) ? 4'd1 : 4'd0;
    if (st_kw_pos == KW_SIZE) st_keepalive = 1'b1;
  endfunction

  function automatic logic [2:0] line_byte(logic [7:0] c);
    logic [4:0] p;
    if (st_phase == PH_REQ) begin
      if (is_blank(c)) begin
        if (st_in_token) begin
          st_in_token = 1'b0;
          if (st_token < TOKEN_MAX) st_token = st_token + 2'd1;
        end
        return CLS_SPACE;
      end
      st_in_token = 1'b1;
      return {1'b0, st_token};
    end
    p = st_line_len;
    if (st_line_len < LINE_POS_MAX) st_line_len = st_line_len + 5'd1;
    if (st_len_hdr) begin
      if (p < LEN_PREFIX_SIZE) begin
        if (lower_case(c) != LEN_PREFIX[p[3:0]]) begin
          st_len_hdr = 1'b0;
        end else if (p == LEN_PREFIX_SIZE - 5'd1) begin
          st_clen      = 31'd0;
          st_num_stage = NUM_SKIP;
          st_num_neg   = 1'b0;
        end
      end else begin
        take_length_char(c);
      end
    end
    if (st_conn_hdr) begin
      if (p < CONN_PREFIX_SIZE) begin
        if (lower_case(c) != CONN_PREFIX[p[3:0]]) begin
          st_conn_hdr = 1'b0;
        end else if (p == CONN_PREFIX_SIZE - 5'd1) begin
          st_keepalive = 1'b0;
          st_kw_pos    = 4'd0;
        end
      end else begin
        take_keyword_char(c);
      end
    end
    return CLS_HEADER;
  endfunction

  function automatic logic finish_line();
    logic done;
    done = 1'b0;
    if (st_phase == PH_REQ) begin
      st_phase = PH_HDR;
    end else if (st_line_len == 5'd0) begin
      if (st_clen > 31'd0) begin
        st_phase     = PH_BODY;
        st_body_seen = 31'd0;
      end else begin
        st_phase = PH_DONE;
        done     = 1'b1;
      end
    end
    restart_line();
    return done;
  endfunction

  function automatic byte_tag_t tag_byte(logic [7:0] c, logic sn);
    byte_tag_t t;
    if (sn) clear_parser();
    t.done = 1'b0;
    if (st_phase == PH_DONE) begin
      t.cls = CLS_AFTER;
    end else if (st_phase == PH_BODY) begin
      t.cls = CLS_BODY;
      st_body_seen = st_body_seen + 31'd1;
      if (st_body_seen >= st_clen) begin
        st_phase = PH_DONE;
        t.done   = 1'b1;
      end
    end else if (c == CHR_CR) begin
      // A CR not followed by LF is an ordinary blank once the next CR shows up.
      if (st_cr_held) void'(line_byte(CHR_CR));
      st_cr_held = 1'b1;
      t.cls = CLS_CRLF;
    end else if (c == CHR_LF && st_cr_held) begin
      st_cr_held = 1'b0;
      t.cls  = CLS_CRLF;
      t.done = finish_line();
    end else begin
      if (st_cr_held) begin
        void'(line_byte(CHR_CR));
        st_cr_held = 1'b0;
      end
      t.cls = line_byte(c);
    end
    t.data  = c;
    t.phase = st_phase;
    t.clen  = st_clen;
    t.keep  = st_keepalive;
    return t;
  endfunction

  function automatic void put(logic [7:0] b, logic sn = 1'b0);
    in_item_t it;
    it       = '0;
    it.b     = b;
    it.sn    = sn;
    tx_bytes.push_back(it);
  endfunction

  function automatic void put_text(string s, bit mix_case);
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (mix_case && $urandom_range(1) == 1 &&
          ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")))
        ch = ch ^ 8'h20;
      put(ch);
    end
  endfunction

  function automatic void put_word(int max_len);
    int n;
    n = $urandom_range(max_len);
    for (int i = 0; i < n; i++)
      put($urandom_range(3) == 0 ? 8'("0" + $urandom_range(9))
                                 : 8'("a" + $urandom_range(25)));
  endfunction

  function automatic void put_sep();
    int n;
    n = $urandom_range(1, 2);
    for (int i = 0; i < n; i++) put($urandom_range(3) == 0 ? 8'h09 : " ");
  endfunction

  // Mostly a clean CRLF; sometimes a stray CR or a lone LF ahead of it.
  function automatic void put_eol();
    case ($urandom_range(9))
      0: put(CHR_CR);
      1: put(CHR_LF);
      default: ;
    endcase
    put(CHR_CR);
    put(CHR_LF);
  endfunction

  function automatic void build_request();
    int first, n, want_len, v;
    first    = tx_bytes.size();
    want_len = -1;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) put(8'($urandom_range(255)), $urandom_range(7) == 0);
      return;
    end
    if ($urandom_range(15) == 0) begin
      put_eol();
    end else begin
      if ($urandom_range(9) == 0) put_sep();
      put_text(verbs[$urandom_range(4)], 1'b0);
      put_sep();
      put("/");
      put_word(6);
      put_sep();
      put_text("HTTP/1.1", 1'b0);
      if ($urandom_range(7) == 0) begin
        put_sep();
        put_word(4);
      end
      put_eol();
    end
    n = $urandom_range(0, 3);
    for (int h = 0; h < n; h++) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          put_text("content-length:", 1'b1);
          for (int i = $urandom_range(2); i > 0; i--) put($urandom_range(1) ? " " : 8'h09);
          v = $urandom_range(7);
          if (v == 0) begin
            put_text($urandom_range(1) ? "-" : "+", 1'b0);
            v = $urandom_range(1, 20);
            put_text($sformatf("%0d", v), 1'b0);
            want_len = -1;
          end else if (v == 1) begin
            // Ten to thirteen nonzero digits: may pass the 31-bit range and saturate.
            for (int i = $urandom_range(10, 13); i > 0; i--) put(8'("1" + $urandom_range(8)));
            want_len = -1;
          end else if (v == 2) begin
            put_text($urandom_range(1) ? "2147483647" : "2147483648", 1'b0);
            want_len = -1;
          end else if (v == 3) begin
            put_text("x12", 1'b0);
            want_len = 0;
          end else begin
            v = $urandom_range(0, 12);
            put_text($sformatf("%0d", v), 1'b0);
            if ($urandom_range(3) == 0) put_text(" 9z", 1'b0);
            want_len = v;
          end
        end
        3, 4: begin
          put_text("connection:", 1'b1);
          put_text(conn_opts[$urandom_range(5)], 1'b1);
        end
        5, 6: begin
          put_text("Host: ", 1'b1);
          put_word(8);
        end
        7: put_text(near_miss[$urandom_range(3)], 1'b1);
        8: for (int i = $urandom_range(20); i > 0; i--) put(8'($urandom_range(255)));
        default: begin
          put_text("X-Padding: ", 1'b1);
          put_word(20);
        end
      endcase
      put_eol();
    end
    if ($urandom_range(9) != 0) begin
      put(CHR_CR);
      put(CHR_LF);
    end
    v = (want_len >= 0) ? want_len : $urandom_range(8);
    if ($urandom_range(3) == 0) v = v + $urandom_range(3);
    else if ($urandom_range(5) == 0 && v > 0) v = v - 1;
    for (int i = 0; i < v; i++) put(8'($urandom_range(255)));
    if (tx_bytes.size() > first && $urandom_range(9) != 0) tx_bytes[first].sn = 1'b1;
  endfunction

  task automatic drive_queue();
    in_item_t it;
    int gap;
    while (tx_bytes.size() != 0) begin
      it = tx_bytes.pop_front();
      if (burst_left == 0) begin
        gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      in_valid  = 1'b1;
      data_byte = it.b;
      start_new = it.sn;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      if (it.typed) begin
        void'(tag_byte(it.b, it.sn));
        tags_due.push_back(it.want);
      end else begin
        tags_due.push_back(tag_byte(it.b, it.sn));
      end
      sent++;
      @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (tags_due.size() != 0) @(negedge clk);
  endtask

  task automatic flag_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(3));
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(4) == 0);
      STALL_HEAVY: out_stall = ($urandom_range(3) != 0);
      default:     out_stall = ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    byte_tag_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tags_due.size() == 0) begin
        flag_mismatch($sformatf("result transfer with byte %02h but none pending", byte_out));
      end else begin
        want = tags_due.pop_front();
        if (byte_out !== want.data)
          flag_mismatch($sformatf("byte_out %02h, want %02h", byte_out, want.data));
        if (byte_class !== want.cls)
          flag_mismatch($sformatf("byte_class %0d, want %0d (byte %02h)",
                                  byte_class, want.cls, want.data));
        if (request_done !== want.done)
          flag_mismatch($sformatf("request_done %0b, want %0b (byte %02h)",
                                  request_done, want.done, want.data));
        if (parse_phase !== want.phase)
          flag_mismatch($sformatf("parse_phase %0d, want %0d (byte %02h)",
                                  parse_phase, want.phase, want.data));
        if (body_length !== want.clen)
          flag_mismatch($sformatf("body_length %0d, want %0d (byte %02h)",
                                  body_length, want.clen, want.data));
        if (conn_persist !== want.keep)
          flag_mismatch($sformatf("conn_persist %0b, want %0b (byte %02h)",
                                  conn_persist, want.keep, want.data));
      end
    end
  end

  initial begin
    in_item_t it;
    int requests;
    requests = 0;
    clear_parser();
    repeat (4) @(negedge clk);
    rst = 1'b0;

    foreach (opening[i]) begin
      it            = '0;
      it.b          = opening[i].b;
      it.sn         = opening[i].sn;
      it.typed      = opening[i].typed;
      it.want.data  = opening[i].b;
      it.want.cls   = opening[i].cls;
      it.want.done  = opening[i].done;
      it.want.phase = opening[i].ph;
      tx_bytes.push_back(it);
    end
    drive_queue();
    drain();

    while (sent < 1800) begin
      build_request();
      drive_queue();
      requests++;
      // Every so often hold off until the output side has caught up.
      if (requests % 8 == 0) drain();
    end

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
